FILE: sv/kpsd_pkg.sv
// Package for the keypad scanner with digit entry: sizes, codes and shared types.
package kpsd_pkg;

    // Digit buffer and keypad geometry
    localparam int NUM_DIGITS = 8;
    localparam int NUM_ROWS   = 4;
    localparam int OUT_DIGITS = 8;

    localparam int ROW_W   = 2;
    localparam int DIGIT_W = 5;
    localparam int KEY_W   = 4;
    localparam int FILL_W  = 5;
    localparam int COL_W   = 4;

    // Digit value that shows nothing
    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 5'd16;
    // Fill position one before position 0 (left entry, empty buffer)
    localparam logic [FILL_W-1:0] FILL_BEFORE_START = 5'd31;

    // Column readback codes of a single pressed key
    localparam logic [COL_W-1:0] COL_FIRST  = 4'b1000;
    localparam logic [COL_W-1:0] COL_SECOND = 4'b0100;
    localparam logic [COL_W-1:0] COL_THIRD  = 4'b0010;
    localparam logic [COL_W-1:0] COL_FOURTH = 4'b0001;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [FILL_W-1:0]  t_fill;

endpackage

FILE: sv/kpsd_if.sv
// Handshake channels of the keypad scanner: poll item in, result item out.
interface kpsd_in_if;
    logic                           valid;
    logic                           ready;
    logic [kpsd_pkg::COL_W-1:0]     column_bits;
    logic                           mode_switch;

    modport source (output valid, output column_bits, output mode_switch, input ready);
    modport sink   (input valid, input column_bits, input mode_switch, output ready);
endinterface

interface kpsd_out_if;
    logic                           valid;
    logic                           ready;
    logic [kpsd_pkg::ROW_W-1:0]     next_row;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_0;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_1;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_2;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_3;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_4;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_5;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_6;
    logic [kpsd_pkg::DIGIT_W-1:0]   digit_7;
    logic                           from_right;
    logic                           display_changed;

    modport source (output valid, output next_row, output digit_0, output digit_1,
                    output digit_2, output digit_3, output digit_4, output digit_5,
                    output digit_6, output digit_7, output from_right,
                    output display_changed, input ready);
    modport sink   (input valid, input next_row, input digit_0, input digit_1,
                    input digit_2, input digit_3, input digit_4, input digit_5,
                    input digit_6, input digit_7, input from_right,
                    input display_changed, output ready);
endinterface

FILE: sv/keypad_scan_digit_entry.sv
// Top level: 4x4 keypad row scanner with an eight-digit entry buffer.
//
// Each input item is one poll of the keypad: the column readback of the row
// that is driven now and the state of mode switch one. The block decodes the
// key (row*4 + 1..4, where the last key wraps to 0), qualifies press and
// release against the scan slot and the key that is held, and shifts a newly
// pressed key into the digit buffer from the right or from the left, with a
// fill position that saturates. A rising edge of the mode switch blanks all
// digits (value 16) and reverses the entry direction; it is handled before the
// key of the same poll. Every poll gives one result item: the row to drive on
// the next poll and the whole buffer. The block takes one item per clock while
// the result side is ready, and the result appears in the cycle after the item
// is accepted, set by the single result register, which also decouples the two
// sides so a new item is taken while the last result is being taken. Reset starts at
// row 0, right entry, fill position at the digit count, no key held, buffer blank.
module keypad_scan_digit_entry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kpsd_in_if.sink      i_item,
    kpsd_out_if.source   o_result
);

    // Scanner and buffer state
    kpsd_pkg::t_row   r_scan_row,   n_scan_row;
    kpsd_pkg::t_row   r_held_slot,  n_held_slot;
    kpsd_pkg::t_key   r_held_key,   n_held_key;
    logic             r_key_held,   n_key_held;
    logic             r_switch_held, n_switch_held;
    logic             r_enter_right, n_enter_right;
    kpsd_pkg::t_fill  r_fill,       n_fill;
    kpsd_pkg::t_digit r_digit [kpsd_pkg::NUM_DIGITS];
    kpsd_pkg::t_digit n_digit [kpsd_pkg::NUM_DIGITS];

    // Result register
    logic             r_out_valid;
    kpsd_pkg::t_row   r_out_row;
    kpsd_pkg::t_digit r_out_digit [kpsd_pkg::OUT_DIGITS];
    logic             r_out_right;
    logic             r_out_changed;

    // Per-poll combinational values
    logic             in_accept;
    logic             key_valid;
    logic             key_entry;
    kpsd_pkg::t_key   key_code;
    logic [kpsd_pkg::KEY_W:0] key_sum;
    logic [2:0]       col_offset;
    logic             changed;
    kpsd_pkg::t_fill  start_pos;
    kpsd_pkg::t_digit src_digit [kpsd_pkg::NUM_DIGITS];
    kpsd_pkg::t_digit out_digit [kpsd_pkg::OUT_DIGITS];

    // Accept a new poll whenever the result register is empty or being drained
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_accept    = i_item.valid && i_item.ready;

    // Key decode: single-bit column codes only, anything else means no key
    always_comb begin
        col_offset = 3'd0;
        key_valid  = 1'b1;
        unique case (i_item.column_bits)
            kpsd_pkg::COL_FIRST:  col_offset = 3'd1;
            kpsd_pkg::COL_SECOND: col_offset = 3'd2;
            kpsd_pkg::COL_THIRD:  col_offset = 3'd3;
            kpsd_pkg::COL_FOURTH: col_offset = 3'd4;
            default:              key_valid  = 1'b0;
        endcase
        key_sum  = {1'b0, r_scan_row, 2'b00} + {2'b00, col_offset};
        // The last key of the last row reads 16 and wraps to 0: drop the carry
        key_code = key_sum[kpsd_pkg::KEY_W-1:0];
    end

    // Next state for one poll: switch edge first, then row advance, release, entry
    always_comb begin
        n_switch_held = i_item.mode_switch;
        n_enter_right = r_enter_right;
        n_fill        = r_fill;
        n_held_slot   = r_held_slot;
        n_held_key    = r_held_key;
        changed       = 1'b0;
        for (int i = 0; i < kpsd_pkg::NUM_DIGITS; i++) begin
            n_digit[i] = r_digit[i];
        end

        // Switch edge: blank the buffer and flip the entry direction
        if (i_item.mode_switch && !r_switch_held) begin
            for (int i = 0; i < kpsd_pkg::NUM_DIGITS; i++) begin
                n_digit[i] = kpsd_pkg::BLANK_DIGIT;
            end
            n_enter_right = !r_enter_right;
            n_fill        = r_enter_right ? kpsd_pkg::FILL_BEFORE_START
                                          : kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS);
            changed       = 1'b1;
        end

        // Advance the row, wrapping at the row count
        if (r_scan_row == kpsd_pkg::t_row'(kpsd_pkg::NUM_ROWS - 1)) begin
            n_scan_row = '0;
        end else begin
            n_scan_row = r_scan_row + kpsd_pkg::t_row'(1);
        end

        // Release: back in the held slot and the reading no longer matches
        n_key_held = r_key_held;
        if (r_key_held && (r_held_slot == n_scan_row) &&
            (!key_valid || (r_held_key != key_code))) begin
            n_key_held = 1'b0;
        end

        for (int i = 0; i < kpsd_pkg::NUM_DIGITS; i++) begin
            src_digit[i] = n_digit[i];
        end
        start_pos = '0;

        // Entry of a fresh key
        key_entry = key_valid && !n_key_held;
        if (key_entry) begin
            n_held_slot = n_scan_row;
            n_held_key  = key_code;
            n_key_held  = 1'b1;
            changed     = 1'b1;
            if (n_enter_right) begin
                if (n_fill != '0) begin
                    n_fill = n_fill - kpsd_pkg::t_fill'(1);
                end
                for (int i = 0; i < kpsd_pkg::NUM_DIGITS - 1; i++) begin
                    if (kpsd_pkg::t_fill'(i) >= n_fill) begin
                        n_digit[i] = src_digit[i + 1];
                    end
                end
                n_digit[kpsd_pkg::NUM_DIGITS - 1] = kpsd_pkg::t_digit'(key_code);
            end else begin
                if (n_fill != kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS - 1)) begin
                    n_fill = n_fill + kpsd_pkg::t_fill'(1);
                end
                start_pos = (n_fill > kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS - 1))
                            ? kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS - 1) : n_fill;
                for (int i = 1; i < kpsd_pkg::NUM_DIGITS; i++) begin
                    if (kpsd_pkg::t_fill'(i) <= start_pos) begin
                        n_digit[i] = src_digit[i - 1];
                    end
                end
                n_digit[0] = kpsd_pkg::t_digit'(key_code);
            end
        end
    end

    // Reported digits: positions past the buffer read blank
    always_comb begin
        for (int j = 0; j < kpsd_pkg::OUT_DIGITS; j++) begin
            if (j < kpsd_pkg::NUM_DIGITS) begin
                out_digit[j] = n_digit[j];
            end else begin
                out_digit[j] = kpsd_pkg::BLANK_DIGIT;
            end
        end
    end

    // State registers: advance only on an accepted poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row    <= '0;
            r_held_slot   <= '0;
            r_held_key    <= '0;
            r_key_held    <= 1'b0;
            r_switch_held <= 1'b0;
            r_enter_right <= 1'b1;
            r_fill        <= kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS);
            for (int i = 0; i < kpsd_pkg::NUM_DIGITS; i++) begin
                r_digit[i] <= kpsd_pkg::BLANK_DIGIT;
            end
        end else if (in_accept) begin
            r_scan_row    <= n_scan_row;
            r_held_slot   <= n_held_slot;
            r_held_key    <= n_held_key;
            r_key_held    <= n_key_held;
            r_switch_held <= n_switch_held;
            r_enter_right <= n_enter_right;
            r_fill        <= n_fill;
            for (int i = 0; i < kpsd_pkg::NUM_DIGITS; i++) begin
                r_digit[i] <= n_digit[i];
            end
        end
    end

    // Result valid: set on accept, clear when taken with nothing new behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_row     <= n_scan_row;
            r_out_right   <= n_enter_right;
            r_out_changed <= changed;
            for (int j = 0; j < kpsd_pkg::OUT_DIGITS; j++) begin
                r_out_digit[j] <= out_digit[j];
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.next_row        = r_out_row;
    assign o_result.digit_0         = r_out_digit[0];
    assign o_result.digit_1         = r_out_digit[1];
    assign o_result.digit_2         = r_out_digit[2];
    assign o_result.digit_3         = r_out_digit[3];
    assign o_result.digit_4         = r_out_digit[4];
    assign o_result.digit_5         = r_out_digit[5];
    assign o_result.digit_6         = r_out_digit[6];
    assign o_result.digit_7         = r_out_digit[7];
    assign o_result.from_right      = r_out_right;
    assign o_result.display_changed = r_out_changed;

`ifndef ASSERT_OFF
    // Fill position stays in the range of its entry direction
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enter_right ? (r_fill <= kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS))
                       : ((r_fill <= kpsd_pkg::t_fill'(kpsd_pkg::NUM_DIGITS - 1)) ||
                          (r_fill == kpsd_pkg::FILL_BEFORE_START))))
        else $error("fill position out of range");

    // An accepted poll always leaves a result waiting
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted poll produced no result");

    // Reported next row is the row the scanner now drives
    a_row_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_result.next_row == r_scan_row))
        else $error("next row does not match scan row");

    // The row steps by one on every poll
    a_row_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_scan_row ==
            (($past(r_scan_row) == kpsd_pkg::t_row'(kpsd_pkg::NUM_ROWS - 1)) ? '0
                : $past(r_scan_row) + kpsd_pkg::t_row'(1))))
        else $error("scan row did not advance");

    // A key shift into the buffer always marks the display as changed
    a_entry_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && key_entry) |=> r_out_changed)
        else $error("key entry not flagged as display change");
`endif

endmodule
